FILE: hw/rtl/hep_pkg.sv
`timescale 1ns / 1ps
// constants, types and step helpers for the hoeffding early prune unit
// stands alone, imported by hoeffding_early_prune_unit

package hep_pkg;

  // seed store geometry
  localparam int unsigned SEEDS      = 1024;
  localparam int unsigned SEED_AW    = $clog2(SEEDS);
  localparam int unsigned SEED_IDX_W = 10;
  localparam int unsigned CNT_W      = $clog2(SEEDS + 1);

  // datapath widths
  localparam int unsigned SCORE_W    = 32;
  localparam int unsigned TOT_W      = SCORE_W + CNT_W;
  localparam int unsigned DIFF_W     = TOT_W + 1;
  localparam int unsigned HALF_W     = (DIFF_W + 1) / 2;
  localparam int unsigned COEFF_W    = 62;
  localparam int unsigned COEFF_LO_W = 31;
  localparam int unsigned MINC_W     = 11;
  localparam int unsigned MUL_W      = 33;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned ACC_W      = 2 * DIFF_W + 2;
  localparam int unsigned SH_W       = $clog2(ACC_W);
  localparam int unsigned STEP_W     = 3;

  // apb port
  localparam int unsigned PDATA_W    = 64;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [SEED_AW-1:0] LAST_SEED = SEED_AW'(SEEDS - 1);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BOUND_COEFF = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_COMMON  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAXIMIZE    = 2'd2;

  // commands
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [STEP_W-1:0] LAST_STEP_REPORT = 3'd4;
  localparam logic [STEP_W-1:0] LAST_STEP_FINISH = 3'd3;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_UPD   = 8'b0000_0100,
    S_ACC   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_CLR   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // weight of each partial product in the accumulator
  function automatic logic [SH_W-1:0] step_shift(logic fin, logic [STEP_W-1:0] step);
    logic [SH_W-1:0] sh;
    sh = '0;
    if (fin) begin
      if (step == 3'd0 || step == 3'd2) sh = SH_W'(HALF_W);
    end else begin
      case (step)
        3'd0:    sh = SH_W'(2 * HALF_W);
        3'd1:    sh = SH_W'(HALF_W + 1);
        3'd3:    sh = SH_W'(COEFF_LO_W);
        default: sh = '0;
      endcase
    end
    return sh;
  endfunction

  // later partial products go to the second accumulator
  function automatic logic step_to_b(logic fin, logic [STEP_W-1:0] step);
    return fin ? (step >= 3'd2) : (step >= 3'd3);
  endfunction

endpackage

FILE: hw/rtl/hoeffding_early_prune_unit.sv
`timescale 1ns / 1ps
// hoeffding early prune unit: per-seed score banks, running sums and the prune test
// depends on hep_pkg

// usage
//   command channel: an item (cmd_i, seed_index_i, score_i, stopped_early_i) is taken
//   at a rising edge with start high and busy low. a report stores one seed score of
//   the current candidate, a finish closes the candidate.
//   result channel: result_valid_o is high for exactly one cycle with prune_o and
//   best_replaced_o; the receiver cannot stall, each result is one transaction.
//   apb port: bound_coeff at 0x00, min_common at 0x08, maximize at 0x10, 64-bit data,
//   no wait states. write only while busy is low and no result is outstanding.
// sequence
//   report: the seed row of both banks is read at the accept edge, updated the next
//   cycle and the sums the one after; the test then runs five 33x33 partial products
//   through the single shared multiplier; busy falls with the result strobe.
//   finish: four partial products for the mean comparison, then the result strobe
//   and with it a clearing pass over the new current bank, one row a cycle; the
//   next item is taken once the pass is over.
// reset
//   a clearing pass writes every row of both banks with busy high; apb writes are
//   taken throughout.

module hoeffding_early_prune_unit
  import hep_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      cmd_i,
  input  logic [SEED_IDX_W-1:0]     seed_index_i,
  input  logic signed [SCORE_W-1:0] score_i,
  input  logic                      stopped_early_i,
  // result channel
  output logic                      result_valid_o,
  output logic                      prune_o,
  output logic                      best_replaced_o,
  // apb configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [COEFF_W-1:0]   bound_coeff_q;
  logic [MINC_W-1:0]    min_common_q;
  logic                 maximize_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_coeff_q <= '0;
      min_common_q  <= MINC_W'(5);
      maximize_q    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BOUND_COEFF: bound_coeff_q <= pwdata[COEFF_W-1:0];
        REG_MIN_COMMON:  min_common_q  <= pwdata[MINC_W-1:0];
        REG_MAXIMIZE:    maximize_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BOUND_COEFF: prdata = PDATA_W'(bound_coeff_q);
      REG_MIN_COMMON:  prdata = PDATA_W'(min_common_q);
      REG_MAXIMIZE:    prdata = PDATA_W'(maximize_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control and running state
  // ---------------------------------------------------------------------------
  state_e                     state_q, state_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [SEED_AW-1:0]         cnt_q, cnt_d;
  logic                       sel_q, sel_d;          // bank holding the current candidate
  logic                       clr_bank_q, clr_bank_d;
  logic [CNT_W-1:0]           cur_seeds_q, cur_seeds_d;
  logic [CNT_W-1:0]           best_seeds_q, best_seeds_d;
  logic [CNT_W-1:0]           common_q, common_d;
  logic signed [TOT_W-1:0]    cur_total_q, cur_total_d;
  logic signed [TOT_W-1:0]    best_total_q, best_total_d;
  logic signed [DIFF_W-1:0]   diff_q, diff_d;
  logic                       res_vld_q, res_vld_d;
  logic                       prune_q, prune_d;
  logic                       repl_q, repl_d;

  // item payload, held while the item is worked on
  logic                       cmd_q;
  logic                       stop_q;
  logic [SEED_AW-1:0]         seed_q;
  logic signed [SCORE_W-1:0]  score_q;

  // deltas found in the update cycle, applied in the next
  logic signed [SCORE_W:0]    dlt_tot_q, dlt_tot_d;
  logic signed [SCORE_W+1:0]  dlt_diff_q, dlt_diff_d;
  logic                       inc_seed_q, inc_seed_d;
  logic                       inc_common_q, inc_common_d;

  logic accept;
  logic seed_in_range;
  logic [STEP_W-1:0] last_step;

  assign busy          = (state_q != S_IDLE);
  assign accept        = start && !busy;
  assign seed_in_range = (32'(seed_index_i) < SEEDS);
  assign last_step     = (cmd_q == CMD_FINISH) ? LAST_STEP_FINISH : LAST_STEP_REPORT;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      stop_q  <= stopped_early_i;
      seed_q  <= SEED_AW'(seed_index_i);
      score_q <= score_i;
    end
  end

  // ---------------------------------------------------------------------------
  // seed banks: one memory per bank, entry = valid bit and score
  // ---------------------------------------------------------------------------
  entry_t             bank0_mem [SEEDS];
  entry_t             bank1_mem [SEEDS];
  entry_t             rd0_q, rd1_q;
  logic               mem_re;
  logic               we0, we1;
  logic [SEED_AW-1:0] raddr, waddr;
  entry_t             wdata;

  assign mem_re = accept && (cmd_i == CMD_REPORT) && seed_in_range;
  assign raddr  = SEED_AW'(seed_index_i);
  // report writes the current bank, clearing passes write zero rows
  assign we0    = (state_q == S_UPD && !sel_q) || (state_q == S_CLR && !clr_bank_q)
                  || (state_q == S_INIT);
  assign we1    = (state_q == S_UPD &&  sel_q) || (state_q == S_CLR &&  clr_bank_q)
                  || (state_q == S_INIT);
  assign waddr  = (state_q == S_UPD) ? seed_q : cnt_q;
  assign wdata  = (state_q == S_UPD) ? entry_t'{valid: 1'b1, score: score_q} : '0;

  always_ff @(posedge clk_i) begin
    if (we0)    bank0_mem[waddr] <= wdata;
    if (mem_re) rd0_q            <= bank0_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we1)    bank1_mem[waddr] <= wdata;
    if (mem_re) rd1_q            <= bank1_mem[raddr];
  end

  // ---------------------------------------------------------------------------
  // read-modify step for a report
  // ---------------------------------------------------------------------------
  entry_t                    cur_e, bst_e;
  logic signed [SCORE_W:0]   sc_x, old_x, bs_x, ref_x;
  logic signed [SCORE_W+1:0] sc_w, ref_w, dd;

  always_comb begin
    cur_e = sel_q ? rd1_q : rd0_q;
    bst_e = sel_q ? rd0_q : rd1_q;
    sc_x  = (SCORE_W + 1)'(score_q);
    old_x = (SCORE_W + 1)'($signed(cur_e.score));
    bs_x  = (SCORE_W + 1)'($signed(bst_e.score));
    // a new seed differs from the best score, a re-report from the old score
    ref_x = cur_e.valid ? old_x : bs_x;
    sc_w  = (SCORE_W + 2)'(sc_x);
    ref_w = (SCORE_W + 2)'(ref_x);
    dd    = maximize_q ? (ref_w - sc_w) : (sc_w - ref_w);

    dlt_diff_d   = bst_e.valid ? dd : '0;
    dlt_tot_d    = cur_e.valid ? (sc_x - old_x) : sc_x;
    inc_seed_d   = !cur_e.valid;
    inc_common_d = !cur_e.valid && bst_e.valid;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      dlt_tot_q    <= dlt_tot_d;
      dlt_diff_q   <= dlt_diff_d;
      inc_seed_q   <= inc_seed_d;
      inc_common_q <= inc_common_d;
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier and two accumulators
  //   report: a = diff^2 from three half products, b = bound_coeff * common
  //   finish: a = current_total * best_seeds, b = best_total * current_seeds
  // ---------------------------------------------------------------------------
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_q;
  logic                     mul_vld_q;
  logic                     acc_fin_q;
  logic [STEP_W-1:0]        acc_step_q;
  logic signed [ACC_W-1:0]  acc_a_q, acc_a_d, acc_b_q, acc_b_d, addend;
  logic [DIFF_W-HALF_W-1:0] m_hi;
  logic [HALF_W-1:0]        m_lo;

  assign m_hi = diff_q[DIFF_W-1:HALF_W];
  assign m_lo = diff_q[HALF_W-1:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (cmd_q == CMD_FINISH) begin
      case (step_q)
        3'd0: begin
          op_a = MUL_W'($signed(cur_total_q[TOT_W-1:HALF_W]));
          op_b = MUL_W'(best_seeds_q);
        end
        3'd1: begin
          op_a = MUL_W'(cur_total_q[HALF_W-1:0]);
          op_b = MUL_W'(best_seeds_q);
        end
        3'd2: begin
          op_a = MUL_W'($signed(best_total_q[TOT_W-1:HALF_W]));
          op_b = MUL_W'(cur_seeds_q);
        end
        3'd3: begin
          op_a = MUL_W'(best_total_q[HALF_W-1:0]);
          op_b = MUL_W'(cur_seeds_q);
        end
        default: ;
      endcase
    end else begin
      case (step_q)
        3'd0: begin
          op_a = MUL_W'(m_hi);
          op_b = MUL_W'(m_hi);
        end
        3'd1: begin
          op_a = MUL_W'(m_hi);
          op_b = MUL_W'(m_lo);
        end
        3'd2: begin
          op_a = MUL_W'(m_lo);
          op_b = MUL_W'(m_lo);
        end
        3'd3: begin
          op_a = MUL_W'(bound_coeff_q[COEFF_W-1:COEFF_LO_W]);
          op_b = MUL_W'(common_q);
        end
        3'd4: begin
          op_a = MUL_W'(bound_coeff_q[COEFF_LO_W-1:0]);
          op_b = MUL_W'(common_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= op_a * op_b;
    acc_fin_q  <= cmd_q;
    acc_step_q <= step_q;
  end

  always_comb begin
    addend  = ACC_W'(prod_q) <<< step_shift(acc_fin_q, acc_step_q);
    acc_a_d = acc_a_q;
    acc_b_d = acc_b_q;
    if (state_q != S_MUL && state_q != S_DRAIN) begin
      acc_a_d = '0;
      acc_b_d = '0;
    end else if (mul_vld_q) begin
      if (step_to_b(acc_fin_q, acc_step_q)) acc_b_d = acc_b_q + addend;
      else                                  acc_a_d = acc_a_q + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= (state_q == S_MUL);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_a_q <= acc_a_d;
    acc_b_q <= acc_b_d;
  end

  // ---------------------------------------------------------------------------
  // decisions
  // ---------------------------------------------------------------------------
  logic a_gt_b, a_lt_b, diff_pos, prune_now, fin_ok, better, upd;

  assign a_gt_b    = (acc_a_q > acc_b_q);
  assign a_lt_b    = (acc_a_q < acc_b_q);
  assign diff_pos  = !diff_q[DIFF_W-1] && (diff_q != '0);
  // squared sum of the seed gaps against the bound, no roots needed
  assign prune_now = (best_seeds_q != '0) && (32'(common_q) >= 32'(min_common_q))
                     && diff_pos && a_gt_b;
  assign fin_ok    = !stop_q && (32'(cur_seeds_q) >= 32'(min_common_q));
  // means compared by cross-multiplication
  assign better    = maximize_q ? a_gt_b : a_lt_b;
  assign upd       = fin_ok && ((best_seeds_q == '0) || better);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    step_d       = '0;
    cnt_d        = cnt_q;
    sel_d        = sel_q;
    clr_bank_d   = clr_bank_q;
    cur_seeds_d  = cur_seeds_q;
    best_seeds_d = best_seeds_q;
    common_d     = common_q;
    cur_total_d  = cur_total_q;
    best_total_d = best_total_q;
    diff_d       = diff_q;
    res_vld_d    = 1'b0;
    prune_d      = prune_q;
    repl_d       = repl_q;

    unique case (state_q)
      S_INIT: begin
        // wipe both banks after reset
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_SEED) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_REPORT && seed_in_range) state_d = S_UPD;
          else                                      state_d = S_MUL;
        end
      end
      S_UPD: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        cur_total_d = cur_total_q + TOT_W'(dlt_tot_q);
        diff_d      = diff_q + DIFF_W'(dlt_diff_q);
        cur_seeds_d = cur_seeds_q + CNT_W'(inc_seed_q);
        common_d    = common_q + CNT_W'(inc_common_q);
        state_d     = S_MUL;
      end
      S_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == last_step) begin
          step_d  = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        res_vld_d = 1'b1;
        if (cmd_q == CMD_FINISH) begin
          prune_d = 1'b0;
          repl_d  = upd;
          if (upd) begin
            // banks swap roles, the old best bank becomes current
            best_seeds_d = cur_seeds_q;
            best_total_d = cur_total_q;
            sel_d        = ~sel_q;
          end
          clr_bank_d  = sel_q ^ upd;
          cur_seeds_d = '0;
          cur_total_d = '0;
          common_d    = '0;
          diff_d      = '0;
          cnt_d       = '0;
          state_d     = S_CLR;
        end else begin
          prune_d = prune_now;
          repl_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_SEED) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        cnt_d   = '0;
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      step_q       <= '0;
      cnt_q        <= '0;
      sel_q        <= 1'b0;
      clr_bank_q   <= 1'b0;
      cur_seeds_q  <= '0;
      best_seeds_q <= '0;
      common_q     <= '0;
      cur_total_q  <= '0;
      best_total_q <= '0;
      diff_q       <= '0;
      res_vld_q    <= 1'b0;
      prune_q      <= 1'b0;
      repl_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      cnt_q        <= cnt_d;
      sel_q        <= sel_d;
      clr_bank_q   <= clr_bank_d;
      cur_seeds_q  <= cur_seeds_d;
      best_seeds_q <= best_seeds_d;
      common_q     <= common_d;
      cur_total_q  <= cur_total_d;
      best_total_q <= best_total_d;
      diff_q       <= diff_d;
      res_vld_q    <= res_vld_d;
      prune_q      <= prune_d;
      repl_q       <= repl_d;
    end
  end

  assign result_valid_o  = res_vld_q;
  assign prune_o         = prune_q;
  assign best_replaced_o = repl_q;

endmodule

FILE: tb/sv/hoeffding_early_prune_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for hoeffding_early_prune_unit: command items in, one decision out each
// builds its own copy of the seed banks and sums and checks prune and best swap bits
// depends on hep_pkg and the unit itself

module hoeffding_early_prune_unit_tb
  import hep_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  // a finish keeps the unit busy for a full bank clear, so allow that much after the last result
  localparam int unsigned SETTLE_CYCLES = 1100;

  typedef struct packed {
    logic prune;
    logic best_replaced;
  } decision_t;

  // clock, reset and unit ports; the driven ones are known from time zero
  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      start           = 1'b0;
  logic                      busy;
  logic                      cmd_i           = CMD_REPORT;
  logic [SEED_IDX_W-1:0]     seed_index_i    = '0;
  logic signed [SCORE_W-1:0] score_i         = '0;
  logic                      stopped_early_i = 1'b0;
  logic                      result_valid_o;
  logic                      prune_o;
  logic                      best_replaced_o;
  logic                      psel            = 1'b0;
  logic                      penable         = 1'b0;
  logic                      pwrite          = 1'b0;
  logic [PADDR_W-1:0]        paddr           = '0;
  logic [PDATA_W-1:0]        pwdata          = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  hoeffding_early_prune_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .seed_index_i    (seed_index_i),
    .score_i         (score_i),
    .stopped_early_i (stopped_early_i),
    .result_valid_o  (result_valid_o),
    .prune_o         (prune_o),
    .best_replaced_o (best_replaced_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // candidate bookkeeping: two banks of per-seed scores, one current and one best
  // ---------------------------------------------------------------------------------------------
  logic [COEFF_W-1:0] coeff_cfg = '0;
  logic [MINC_W-1:0]  min_cfg   = MINC_W'(5);
  logic               max_cfg   = 1'b1;

  logic [SCORE_W-1:0] score_bank [2][SEEDS];
  bit                 valid_bank [2][SEEDS];
  bit                 cur_sel;
  int unsigned        cur_seeds, best_seeds, common_seeds;
  longint             cur_total, best_total, diff_total;

  decision_t pending_decisions[$];
  bit        last_prune;

  // run statistics and failure count
  int unsigned mismatches, items_sent, finishes_sent, swaps_seen, prunes_seen, settings_written;
  int unsigned results_seen, cycle_count;
  int unsigned sender_idle_pct;
  bit          cmd_req;

  // per-seed gap, positive when the current candidate is worse
  function automatic longint seed_gap(input longint best_score, input longint cur_score);
    return max_cfg ? best_score - cur_score : cur_score - best_score;
  endfunction

  // root-free hoeffding test: diff^2 > coeff * common, exact in 128 bits
  function automatic bit prune_holds();
    logic [127:0] diff_sq, bound;
    if (best_seeds == 0 || common_seeds < min_cfg || diff_total <= 0) return 1'b0;
    diff_sq = 128'(diff_total) * 128'(diff_total);
    bound   = 128'(coeff_cfg) * 128'(common_seeds);
    return diff_sq > bound;
  endfunction

  // advance the candidate state by one item and return the decision it yields
  function automatic decision_t apply_seed_item(input logic cmd,
                                                input logic [SEED_IDX_W-1:0] seed,
                                                input logic signed [SCORE_W-1:0] score,
                                                input logic stop);
    decision_t d;
    bit        cur, bst, seen_best, swap;
    longint    new_score, best_score, old_score, lhs, rhs;
    d    = '0;
    cur  = cur_sel;
    bst  = !cur_sel;
    swap = 1'b0;
    if (cmd == CMD_REPORT) begin
      if (seed < SEEDS) begin
        new_score  = longint'(score);
        seen_best  = valid_bank[bst][seed];
        best_score = seen_best ? longint'($signed(score_bank[bst][seed])) : 64'sd0;
        if (!valid_bank[cur][seed]) begin
          valid_bank[cur][seed] = 1'b1;
          cur_seeds++;
          if (seen_best) begin
            common_seeds++;
            diff_total += seed_gap(best_score, new_score);
          end
        end else begin
          // re-reported seed: swap the old score out of both sums
          old_score = longint'($signed(score_bank[cur][seed]));
          cur_total -= old_score;
          if (seen_best)
            diff_total += seed_gap(best_score, new_score) - seed_gap(best_score, old_score);
        end
        score_bank[cur][seed] = score;
        cur_total += new_score;
      end
    end else begin
      if (!stop && cur_seeds >= min_cfg) begin
        if (best_seeds == 0) begin
          swap = 1'b1;
        end else begin
          // strict mean comparison by cross-multiplication
          lhs  = cur_total * longint'(best_seeds);
          rhs  = best_total * longint'(cur_seeds);
          swap = max_cfg ? (lhs > rhs) : (lhs < rhs);
        end
        if (swap) begin
          best_seeds      = cur_seeds;
          best_total      = cur_total;
          cur_sel         = bst;
          d.best_replaced = 1'b1;
        end
      end
      // the bank now current is cleared, whether or not the roles swapped
      for (int i = 0; i < SEEDS; i++) valid_bank[cur_sel][i] = 1'b0;
      cur_seeds    = 0;
      cur_total    = 0;
      common_seeds = 0;
      diff_total   = 0;
    end
    d.prune = prune_holds();
    return d;
  endfunction

  task automatic note_mismatch(input string what, input logic [PDATA_W-1:0] want,
                               input logic [PDATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h (result %0d)", what, want, got,
               results_seen);
  endtask

  // ---------------------------------------------------------------------------------------------
  // result checker: every strobe is one transaction, compared with the oldest decision
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    decision_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      results_seen++;
      if (pending_decisions.size() == 0) begin
        note_mismatch("unexpected result", '0, 64'd1);
      end else begin
        want = pending_decisions.pop_front();
        if (prune_o !== want.prune)
          note_mismatch("prune", PDATA_W'(want.prune), PDATA_W'(prune_o));
        if (best_replaced_o !== want.best_replaced)
          note_mismatch("best_replaced", PDATA_W'(want.best_replaced),
                        PDATA_W'(best_replaced_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d decisions pending", cycle_count,
               pending_decisions.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------------------------

  // drop start and hold off until every decision is back and the unit is idle
  task automatic wait_idle();
    if (cmd_req) begin
      start   <= 1'b0;
      cmd_req  = 1'b0;
    end
    while (pending_decisions.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  // one command transaction; start stays high after acceptance unless a gap follows
  task automatic send_item(input logic cmd, input logic [SEED_IDX_W-1:0] seed,
                           input logic signed [SCORE_W-1:0] score, input logic stop);
    int unsigned gap;
    decision_t   d;
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      if (cmd_req) begin
        start   <= 1'b0;
        cmd_req  = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    cmd_req          = 1'b1;
    cmd_i           <= cmd;
    seed_index_i    <= seed;
    score_i         <= score;
    stopped_early_i <= stop;
    do @(posedge clk_i); while (busy !== 1'b0);
    d = apply_seed_item(cmd, seed, score, stop);
    pending_decisions.push_back(d);
    last_prune = d.prune;
    items_sent++;
    if (cmd == CMD_FINISH) finishes_sent++;
    if (d.best_replaced) swaps_seen++;
    if (d.prune) prunes_seen++;
  endtask

  // ---------------------------------------------------------------------------------------------
  // apb side
  // ---------------------------------------------------------------------------------------------

  // setup then access phase, then psel and penable drop again
  task automatic apb_transfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    apb_transfer(1'b0, idx, '0, got);
    if (got !== want) note_mismatch("register readback", want, got);
  endtask

  // only ever called with the unit idle; the local copy follows the write
  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] unused_rdata, want;
    wait_idle();
    apb_transfer(1'b1, idx, value, unused_rdata);
    want = '0;
    case (idx)
      REG_BOUND_COEFF: begin
        coeff_cfg = value[COEFF_W-1:0];
        want      = PDATA_W'(coeff_cfg);
      end
      REG_MIN_COMMON: begin
        min_cfg = value[MINC_W-1:0];
        want    = PDATA_W'(min_cfg);
      end
      REG_MAXIMIZE: begin
        max_cfg = value[0];
        want    = PDATA_W'(max_cfg);
      end
      default: want = '0;
    endcase
    settings_written++;
    check_register(idx, want);
  endtask

  // ---------------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------------

  // reset values, then both ends of bound_coeff and maximize and 1024 and 1 for min_common, then back to reset values
  task automatic test_register_access();
    wait_idle();
    check_register(REG_BOUND_COEFF, 64'd0);
    check_register(REG_MIN_COMMON, 64'd5);
    check_register(REG_MAXIMIZE, 64'd1);
    write_register(REG_BOUND_COEFF, PDATA_W'({COEFF_W{1'b1}}));
    write_register(REG_MIN_COMMON, 64'd1024);
    write_register(REG_MAXIMIZE, 64'd0);
    write_register(REG_BOUND_COEFF, 64'd0);
    write_register(REG_MIN_COMMON, 64'd1);
    write_register(REG_MIN_COMMON, 64'd5);
    write_register(REG_MAXIMIZE, 64'd1);
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    // finish with no seeds and no best yet: nothing kept, report fields ignored
    send_item(CMD_FINISH, '1, 32'sh7FFF_FFFF, 1'b0);
    // first candidate over the seed and score extremes, stopped_early ignored on a report
    send_item(CMD_REPORT, 10'd0, 32'sd100, 1'b1);
    send_item(CMD_REPORT, 10'd1023, 32'sh7FFF_FFFF, 1'b0);
    send_item(CMD_REPORT, 10'd512, 32'sh8000_0000, 1'b0);
    send_item(CMD_REPORT, 10'd341, -32'sd1, 1'b0);
    send_item(CMD_REPORT, 10'd682, 32'sd0, 1'b0);
    // re-reported seed replaces its old score
    send_item(CMD_REPORT, 10'd512, 32'sd200, 1'b0);
    // no best yet, so this one is kept
    send_item(CMD_FINISH, 10'd0, 32'sd0, 1'b0);
    // worse on every common seed; with a zero coefficient prune rises at min_common seeds
    send_item(CMD_REPORT, 10'd0, -32'sd100, 1'b0);
    send_item(CMD_REPORT, 10'd1023, 32'sh7FFF_FF00, 1'b0);
    send_item(CMD_REPORT, 10'd512, 32'sh8000_0000, 1'b0);
    send_item(CMD_REPORT, 10'd341, -32'sd5, 1'b0);
    send_item(CMD_REPORT, 10'd682, -32'sd1000, 1'b0);
    // sense flipped mid-candidate: the re-report's gap is taken the new way round
    write_register(REG_MAXIMIZE, 64'd0);
    send_item(CMD_REPORT, 10'd0, 32'sd500, 1'b0);
    write_register(REG_MAXIMIZE, 64'd1);
    // a candidate flagged as stopped early is never kept
    send_item(CMD_FINISH, 10'd7, -32'sd7, 1'b1);
    // too few seeds to be kept however good the scores
    send_item(CMD_REPORT, 10'd1, 32'sd1000, 1'b0);
    send_item(CMD_REPORT, 10'd2, 32'sd1000, 1'b0);
    send_item(CMD_REPORT, 10'd3, 32'sd1000, 1'b0);
    send_item(CMD_REPORT, 10'd4, 32'sd1000, 1'b0);
    send_item(CMD_FINISH, 10'd0, 32'sd0, 1'b0);
    // better mean on enough seeds: the banks swap roles
    for (int i = 100; i < 105; i++) send_item(CMD_REPORT, SEED_IDX_W'(i), 32'sh7FFF_FFFF, 1'b0);
    send_item(CMD_FINISH, '0, '0, 1'b0);
  endtask

  // fresh register settings, extremes included, written with the unit drained
  task automatic retune_settings();
    logic [COEFF_W-1:0] coeff;
    int unsigned        r, minc;
    case ($urandom_range(0, 6))
      0:       coeff = '0;
      1:       coeff = COEFF_W'(1);
      2:       coeff = COEFF_W'($urandom_range(1, 1 << 16));
      3, 4:    coeff = COEFF_W'($urandom_range(1 << 16, 1 << 26));
      5:       coeff = '1;
      default: coeff = COEFF_W'({$urandom(), $urandom()});
    endcase
    r = $urandom_range(0, 99);
    if (r < 15)      minc = 1;
    else if (r < 20) minc = 1024;
    else if (r < 25) minc = $urandom_range(1, 1024);
    else             minc = $urandom_range(2, 8);
    write_register(REG_BOUND_COEFF, PDATA_W'(coeff));
    write_register(REG_MIN_COMMON, PDATA_W'(minc));
    write_register(REG_MAXIMIZE, PDATA_W'($urandom_range(0, 1)));
  endtask

  // candidate sequences over a shared seed window so that common seeds build up;
  // early finishes after a prune, abandoned and empty candidates mixed in
  task automatic test_random_candidates(input int unsigned idle_pct, input int unsigned budget);
    int unsigned               sent, len, base, k;
    int                        mean;
    logic [SEED_IDX_W-1:0]     seed;
    logic signed [SCORE_W-1:0] score;
    logic                      stop;
    sender_idle_pct = idle_pct;
    sent = 0;
    base = $urandom_range(0, SEEDS - 32);
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 20) retune_settings();
      if ($urandom_range(0, 99) < 15) base = $urandom_range(0, SEEDS - 32);
      len = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 4) : $urandom_range(5, 24);
      case ($urandom_range(0, 19))
        0:       mean = 2147482000;
        1:       mean = -2147482000;
        default: mean = int'($urandom_range(0, 4000)) - 2000;
      endcase
      stop = 1'b0;
      for (k = 0; k < len && !stop; k++) begin
        if ($urandom_range(0, 99) < 90) seed = SEED_IDX_W'(base + $urandom_range(0, 31));
        else                            seed = SEED_IDX_W'($urandom_range(0, SEEDS - 1));
        if ($urandom_range(0, 99) < 5) score = $urandom();
        else                           score = mean + int'($urandom_range(0, 400)) - 200;
        send_item(CMD_REPORT, seed, score, 1'($urandom_range(0, 1)));
        sent++;
        // tuning loop gives up on a pruned candidate most of the time
        if (last_prune && $urandom_range(0, 99) < 60) stop = 1'b1;
      end
      if (!stop && $urandom_range(0, 99) < 15) stop = 1'b1;
      send_item(CMD_FINISH, SEED_IDX_W'($urandom()), $urandom(), stop);
      sent++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_cases();
    // sender idles often, then very often, then never; the receiver cannot stall
    test_random_candidates(35, 460);
    test_random_candidates(69, 460);
    test_random_candidates(0, 460);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d transactions, %0d of them finishes, over %0d register writes",
             items_sent, finishes_sent, settings_written);
    $display("saw %0d best swaps and %0d prune decisions, %0d mismatches",
             swaps_seen, prunes_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/hep_pkg.sv
hw/rtl/hoeffding_early_prune_unit.sv
tb/sv/hoeffding_early_prune_unit_tb.sv
